### hw/rtl/bce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bce_pkg;

  localparam int unsigned CODE_LEN = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes on the config port
  localparam logic [1:0] REG_CHAR_SET   = 2'd0;
  localparam logic [1:0] REG_MSB_FIRST  = 2'd1;
  localparam logic [1:0] REG_START_BITS = 2'd2;
  localparam logic [1:0] REG_STOP_BITS  = 2'd3;

  // character sets
  localparam logic [2:0] SET_ITA2    = 3'd0;
  localparam logic [2:0] SET_UK      = 3'd1;
  localparam logic [2:0] SET_EURO    = 3'd2;
  localparam logic [2:0] SET_US      = 3'd3;
  localparam logic [2:0] SET_RUSSIAN = 3'd4;
  localparam logic [2:0] SET_MURRAY  = 3'd5;

  // shift pages
  localparam logic [1:0] PAGE_LET = 2'd0;
  localparam logic [1:0] PAGE_FIG = 2'd1;
  localparam logic [1:0] PAGE_CYR = 2'd2;

  // table ids
  localparam logic [3:0] T_ITA2L = 4'd0;
  localparam logic [3:0] T_ITA2F = 4'd1;
  localparam logic [3:0] T_UKL   = 4'd2;
  localparam logic [3:0] T_UKF   = 4'd3;
  localparam logic [3:0] T_EUL   = 4'd4;
  localparam logic [3:0] T_EUF   = 4'd5;
  localparam logic [3:0] T_USF   = 4'd6;
  localparam logic [3:0] T_RUF   = 4'd7;
  localparam logic [3:0] T_MUL   = 4'd8;
  localparam logic [3:0] T_MUF   = 4'd9;
  localparam logic [3:0] T_CYR   = 4'd10;

  localparam logic [15:0] CH_TO_LET = 16'h003E;
  localparam logic [15:0] CH_TO_FIG = 16'h003C;
  localparam logic [15:0] CH_NUL    = 16'h0000;

  // entry that matches no code unit
  localparam logic [16:0] N = 17'h10000;

  localparam logic [16:0] SHIFT_CHAR [3] = '{17'h3E, 17'h3C, 17'h00};

  localparam logic [16:0] TABS [11][32] = '{
    '{17'h0, 17'h45, 17'h0A, 17'h41, 17'h20, 17'h53, 17'h49, 17'h55,
      17'h0D, 17'h44, 17'h52, 17'h4A, 17'h4E, 17'h46, 17'h43, 17'h4B,
      17'h54, 17'h5A, 17'h4C, 17'h57, 17'h48, 17'h59, 17'h50, 17'h51,
      17'h4F, 17'h42, 17'h47, 17'h3C, 17'h4D, 17'h58, 17'h56, 17'h3E},
    '{17'h0, 17'h33, 17'h0A, 17'h2D, 17'h20, 17'h27, 17'h38, 17'h37,
      17'h0D, 17'h05, 17'h34, 17'h07, 17'h2C, 17'h21, 17'h3A, 17'h28,
      17'h35, 17'h2B, 17'h29, 17'h32, 17'hA3, 17'h36, 17'h30, 17'h31,
      17'h39, 17'h3F, 17'h26, 17'h3C, 17'h2E, 17'h2F, 17'h3D, 17'h3E},
    '{17'h0, 17'h41, 17'h45, 17'h2F, 17'h59, 17'h55, 17'h49, 17'h4F,
      17'h3C, 17'h4A, 17'h47, 17'h48, 17'h42, 17'h43, 17'h46, 17'h44,
      17'h20, 17'h2D, 17'h58, 17'h5A, 17'h53, 17'h54, 17'h57, 17'h56,
      17'h08, 17'h4B, 17'h4D, 17'h4C, 17'h52, 17'h51, 17'h4E, 17'h50},
    '{17'h0, 17'h31, 17'h32, 17'h215F, 17'h33, 17'h34, N, 17'h35,
      17'h20, 17'h36, 17'h37, 17'hB9, 17'h38, 17'h39, N, 17'h30,
      17'h3E, 17'h2E, N, 17'h3A, N, 17'hB2, 17'h3F, 17'h27,
      17'h08, 17'h28, 17'h29, 17'h3D, 17'h2D, 17'h2F, 17'hA3, 17'h2B},
    '{17'h0, 17'h41, 17'h45, 17'hC9, 17'h59, 17'h55, 17'h49, 17'h4F,
      17'h3C, 17'h4A, 17'h47, 17'h48, 17'h42, 17'h43, 17'h46, 17'h44,
      17'h20, 17'h74, 17'h58, 17'h5A, 17'h53, 17'h54, 17'h57, 17'h56,
      17'h08, 17'h4B, 17'h4D, 17'h4C, 17'h52, 17'h51, 17'h4E, 17'h50},
    '{17'h0, 17'h31, 17'h32, 17'h26, 17'h33, 17'h34, 17'hBA, 17'h35,
      17'h20, 17'h36, 17'h37, N, 17'h38, 17'h39, N, 17'h30,
      17'h3E, 17'h2E, 17'h2C, 17'h3A, 17'h3B, 17'h21, 17'h3F, 17'h27,
      17'h08, 17'h28, 17'h29, 17'h3D, 17'h2D, 17'h2F, 17'h2116, 17'h25},
    '{17'h0, 17'h33, 17'h0A, 17'h2D, 17'h20, 17'h07, 17'h38, 17'h37,
      17'h0D, 17'h05, 17'h34, 17'h27, 17'h2C, 17'h21, 17'h3A, 17'h28,
      17'h35, 17'h22, 17'h29, 17'h32, 17'h23, 17'h36, 17'h30, 17'h31,
      17'h39, 17'h3F, 17'h26, 17'h3C, 17'h2E, 17'h2F, 17'h3B, 17'h3E},
    '{17'h0, 17'h33, 17'h0A, 17'h2D, 17'h20, 17'h27, 17'h38, 17'h37,
      17'h0D, 17'h427, 17'h34, 17'h42E, 17'h2C, 17'h42D, 17'h3A, 17'h28,
      17'h35, 17'h2B, 17'h29, 17'h32, 17'h429, 17'h36, 17'h30, 17'h31,
      17'h39, 17'h3F, 17'h428, 17'h3C, 17'h2E, 17'h2F, 17'h3B, 17'h3E},
    '{17'h20, 17'h45, 17'h3F, 17'h41, 17'h3E, 17'h53, 17'h49, 17'h55,
      17'h0A, 17'h44, 17'h52, 17'h4A, 17'h4E, 17'h46, 17'h43, 17'h4B,
      17'h54, 17'h5A, 17'h4C, 17'h57, 17'h48, 17'h59, 17'h50, 17'h51,
      17'h4F, 17'h42, 17'h47, 17'h3C, 17'h4D, 17'h58, 17'h56, 17'h08},
    '{17'h20, 17'h33, 17'h3F, 17'h20, 17'h3E, 17'h27, 17'h38, 17'h37,
      17'h0A, 17'hB2, 17'h34, N, 17'h2D, 17'h215F, 17'h28, N,
      17'h35, 17'h2E, 17'h2F, 17'h32, N, 17'h36, 17'h30, 17'h31,
      17'h39, 17'h3F, N, 17'h3C, 17'h2C, 17'hA3, 17'h29, 17'h08},
    '{17'h0, 17'h415, 17'h0A, 17'h410, 17'h20, 17'h421, 17'h418, 17'h423,
      17'h0D, 17'h414, 17'h420, 17'h419, 17'h427, 17'h424, 17'h426, 17'h41A,
      17'h422, 17'h417, 17'h41B, 17'h412, 17'h425, 17'h42B, 17'h41F, 17'h42F,
      17'h41E, 17'h411, 17'h413, 17'h3C, 17'h41C, 17'h42C, 17'h416, 17'h3E}
  };

  // one queued item: number of codes and the codes in send order
  typedef struct packed {
    logic [1:0] ncode;
    logic [4:0] code0;
    logic [4:0] code1;
  } cmd_t;

  // framing settings for the back end
  typedef struct packed {
    logic       msb_first;
    logic       start_bits;
    logic [1:0] stop_bits;
  } frame_cfg_t;

endpackage
`default_nettype wire

### hw/rtl/baudot_character_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | transfers
// s_*      | in        | one character, tdata = char_in
// m_*      | out       | one result, tdata = frame_bits, bit_count; tuser = found
// cfg_*    | in        | register write, index and data
//
// one character per cycle while the queue is not full; the front end matches it against the
// code tables in the cycle it is taken, the back end frames it once it leaves the queue.
// a result is held in the queue and then in the output register of the back end.
// reset selects ITA2, the letters page and the default framing (one start, one stop).
// a two-entry queue decouples the sides; input stalls only when it is full.
module baudot_character_encoder #(
  parameter int unsigned QDEPTH = bce_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] char_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] frame_bits, [20:16] bit_count, rest zero
  output logic [0:0]       m_tuser,   // [0] found
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_data
);
  import bce_pkg::*;

  logic [2:0]  char_set;
  frame_cfg_t  fcfg;
  cmd_t        f_cmd;
  cmd_t        q_cmd;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        take;
  logic [15:0] frame_bits;
  logic [4:0]  bit_count;
  logic        found;

  assign cfg_ready = 1'b1;
  assign s_tready = !q_full;
  assign take = s_tvalid && !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_set <= SET_ITA2;
      fcfg.msb_first <= 1'b0;
      fcfg.start_bits <= 1'b1;
      fcfg.stop_bits <= 2'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHAR_SET:   char_set <= (cfg_data > SET_MURRAY) ? SET_ITA2 : cfg_data;
        REG_MSB_FIRST:  fcfg.msb_first <= cfg_data[0];
        REG_START_BITS: fcfg.start_bits <= cfg_data[0];
        REG_STOP_BITS:  fcfg.stop_bits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  bce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .char_in  (s_tdata),
    .char_set (char_set),
    .cmd      (f_cmd)
  );

  bce_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_cmd)
  );

  bce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_cmd),
    .q_pop      (q_pop),
    .fcfg       (fcfg),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .frame_bits (frame_bits),
    .bit_count  (bit_count),
    .found      (found)
  );

  assign m_tdata = {3'd0, bit_count, frame_bits};
  assign m_tuser = found;

endmodule
`default_nettype wire

### hw/rtl/bce_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bce_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [15:0]       char_in,
  input  wire logic [2:0]        char_set,
  output bce_pkg::cmd_t          cmd
);
  import bce_pkg::*;

  logic [1:0] page;
  logic [1:0] page_next;

  // upper-case folding
  function automatic logic [15:0] fold(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    if (c >= 16'h61 && c <= 16'h7A) r = c - 16'h20;
    else if (c >= 16'hE0 && c <= 16'hFE && c != 16'hF7) r = c - 16'h20;
    else if (c == 16'hFF) r = 16'h178;
    else if (c == 16'hB5) r = 16'h39C;
    else if (c >= 16'h430 && c <= 16'h44F) r = c - 16'h20;
    else if (c >= 16'h450 && c <= 16'h45F) r = c - 16'h50;
    return r;
  endfunction

  // table used by a page under a set
  function automatic logic [3:0] tab_id(input logic [2:0] cs, input logic [1:0] p);
    logic [3:0] r;
    r = T_CYR;
    if (p != PAGE_CYR) begin
      unique case (cs)
        SET_UK:      r = (p == PAGE_LET) ? T_UKL : T_UKF;
        SET_EURO:    r = (p == PAGE_LET) ? T_EUL : T_EUF;
        SET_US:      r = (p == PAGE_LET) ? T_ITA2L : T_USF;
        SET_RUSSIAN: r = (p == PAGE_LET) ? T_ITA2L : T_RUF;
        SET_MURRAY:  r = (p == PAGE_LET) ? T_MUL : T_MUF;
        default:     r = (p == PAGE_LET) ? T_ITA2L : T_ITA2F;
      endcase
    end
    return r;
  endfunction

  // lowest matching code, bit 5 set on a hit
  function automatic logic [5:0] find_code(input logic [3:0] t, input logic [16:0] c);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (TABS[t][i] == c) r = {1'b1, 5'(i)};
    end
    return r;
  endfunction

  logic [15:0] c;
  logic [3:0]  cur_t;
  logic        russian;
  logic [5:0]  m_cur;
  logic [5:0]  m_oth;
  logic [5:0]  m_sh;
  logic        done;

  // classify the character and pick its codes
  always_comb begin
    c = fold(char_in);
    cur_t = tab_id(char_set, page);
    russian = (char_set == SET_RUSSIAN);
    m_cur = find_code(cur_t, {1'b0, c});
    m_oth = '0;
    m_sh = '0;
    done = 1'b0;
    cmd = '0;
    page_next = page;
    if (c == CH_TO_LET || c == CH_TO_FIG || (russian && c == CH_NUL)) begin
      if (m_cur[5]) begin
        cmd.ncode = 2'd1;
        cmd.code0 = m_cur[4:0];
        page_next = (c == CH_TO_LET) ? PAGE_LET : (c == CH_TO_FIG) ? PAGE_FIG : PAGE_CYR;
      end
    end else if (m_cur[5]) begin
      cmd.ncode = 2'd1;
      cmd.code0 = m_cur[4:0];
    end else begin
      for (int p = 0; p < 3; p++) begin
        if (!done && page != 2'(p) && (p < 2 || russian)) begin
          m_oth = find_code(tab_id(char_set, 2'(p)), {1'b0, c});
          if (m_oth[5]) begin
            done = 1'b1;
            m_sh = find_code(cur_t, SHIFT_CHAR[p]);
            if (m_sh[5]) begin
              cmd.ncode = 2'd2;
              cmd.code0 = m_sh[4:0];
              cmd.code1 = m_oth[4:0];
              page_next = 2'(p);
            end
          end
        end
      end
    end
  end

  // shift page
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= PAGE_LET;
    end else if (take) begin
      page <= page_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bce_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bce_queue #(
  parameter int unsigned DEPTH = bce_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  bce_pkg::cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output bce_pkg::cmd_t pop_data
);
  import bce_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bce_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bce_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  bce_pkg::cmd_t       q_data,
  output logic                q_pop,
  input  bce_pkg::frame_cfg_t fcfg,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [15:0]         frame_bits,
  output logic [4:0]          bit_count,
  output logic                found
);
  import bce_pkg::*;

  logic [1:0]  stop;
  logic [3:0]  len;
  logic [7:0]  f0;
  logic [7:0]  f1;
  logic [15:0] bits_next;
  logic [4:0]  cnt_next;

  // one framed code: start bits, five code bits, stop bits
  function automatic logic [7:0] frame(input logic [4:0] code, input frame_cfg_t fc,
                                       input logic [1:0] stp);
    logic [4:0] cb;
    logic [7:0] r;
    cb = code;
    if (fc.msb_first) begin
      for (int i = 0; i < CODE_LEN; i++) cb[i] = code[CODE_LEN - 1 - i];
    end
    r = 8'({cb, 1'b0} >> (1 - fc.start_bits));
    r = r | 8'((8'((1 << stp) - 1)) << (3'(CODE_LEN) + 3'(fc.start_bits)));
    return r;
  endfunction

  // pack one or two codes
  always_comb begin
    stop = (fcfg.stop_bits > 2'd2) ? 2'd2 : fcfg.stop_bits;
    len = 4'(CODE_LEN) + 4'(fcfg.start_bits) + 4'(stop);
    f0 = frame(q_data.code0, fcfg, stop);
    f1 = frame(q_data.code1, fcfg, stop);
    bits_next = '0;
    cnt_next = '0;
    if (q_data.ncode == 2'd1) begin
      bits_next = {8'd0, f0};
      cnt_next = 5'(len);
    end else if (q_data.ncode == 2'd2) begin
      bits_next = {8'd0, f0} | ({8'd0, f1} << len);
      cnt_next = 5'({len, 1'b0});
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_bits <= bits_next;
      bit_count <= cnt_next;
      found <= (q_data.ncode != 2'd0);
    end
  end

endmodule
`default_nettype wire
